FILE: rtl/lcd_segment_serial_writer_macros.svh
// Assertion macros shared by the segment LCD writer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef LCD_SEGMENT_SERIAL_WRITER_MACROS_SVH
`define LCD_SEGMENT_SERIAL_WRITER_MACROS_SVH

// Check a same-cycle implication, disabled while reset is low.
`define LCDSSW_ASSERT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// Check that a condition holds in the cycle after the trigger.
`define LCDSSW_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

FILE: rtl/lcdssw_pkg.sv
// Shared types and constants of the segment LCD serial writer.
// No dependencies; used by lcdssw_store and lcd_segment_serial_writer.
package lcdssw_pkg;

    localparam int SEG_ADDR_W = 5;
    localparam int SEG_BITS_W = 4;
    localparam int CMD_W      = 8;

    // Frame layout: preamble of three bits, then command, or zero padding + nibbles.
    localparam int CMD_FRAME_BITS = 12;
    localparam int HEADER_BITS    = 9;
    localparam int CMD_LAST_POS   = 10;

    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_SET_BITS  = 3'd1,
        FUNC_CLR_BITS  = 3'd2,
        FUNC_FILL_ONES = 3'd3,
        FUNC_CLEAR_ALL = 3'd4,
        FUNC_COMMAND   = 3'd5,
        FUNC_REFRESH   = 3'd6
    } t_func;

    typedef struct packed {
        logic                  set_bits;
        logic                  clear_bits;
        logic                  fill_ones;
        logic                  clear_all;
        logic [SEG_ADDR_W-1:0] addr;
        logic [SEG_BITS_W-1:0] bits;
    } t_store_ctl;

endpackage

FILE: rtl/lcd_segment_serial_writer.sv
// Top level of the segment LCD serial writer: input register, frame sequencer,
// output register. Depends on lcdssw_pkg, lcdssw_store and the macros header.
//
//  channel | dir | tdata                                   | tuser         | tlast
//  --------+-----+-----------------------------------------+---------------+-----------
//  s       | in  | [4:0] seg_address [8:5] seg_bits        | [2:0] func    | -
//          |     | [16:9] command_code, pad to 24 bits     |               |
//  m       | out | [0] data_bit [1] chip_select, pad to 8  | [0] frame_kind| frame_last
//
// One transfer is taken per cycle while s_tready is high; each item passes through the input
// register, and its result, if any, is loaded into the output register as the item leaves the input register.
// The input register drains only when the output register is free or being read, so a
// stall on the m side backs up to s_tready in the same cycle.
// Reset (synchronous, active low) clears the store, the sequencer and both valid flags.
`include "lcd_segment_serial_writer_macros.svh"

module lcd_segment_serial_writer #(
    parameter int BUFFER_NIBBLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [4:0] seg_address, [8:5] seg_bits, [16:9] command_code
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] data_bit, [1] chip_select
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser    // [0] frame_kind
);

    localparam int WRITE_FRAME_BITS = lcdssw_pkg::HEADER_BITS + 4 * BUFFER_NIBBLES;
    localparam int POS_W            = $clog2(WRITE_FRAME_BITS);
    localparam int BIT_IDX_W        = $clog2(4 * BUFFER_NIBBLES);

    // Input register.
    logic                              r_in_valid;
    lcdssw_pkg::t_func                 r_in_func;
    logic [lcdssw_pkg::SEG_ADDR_W-1:0] r_in_addr;
    logic [lcdssw_pkg::SEG_BITS_W-1:0] r_in_bits;
    logic [lcdssw_pkg::CMD_W-1:0]      r_in_cmd;

    // Frame sequencer.
    logic                         r_active;
    logic                         r_kind;
    logic [lcdssw_pkg::CMD_W-1:0] r_cmd;
    logic [POS_W-1:0]             r_pos;

    // Output register.
    logic r_out_valid;
    logic r_out_bit;
    logic r_out_last;
    logic r_out_kind;

    logic                   accept_in;
    logic                   out_free;
    logic                   advance;
    logic                   emit;
    logic                   start;
    logic                   n_last;
    logic                   n_bit;
    logic                   cmd_bit;
    logic                   store_bit;
    logic [3:0]             cmd_idx;
    logic [POS_W-1:0]       seg_pos;
    logic [POS_W-1:0]       last_pos;
    lcdssw_pkg::t_store_ctl store_ctl;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign accept_in  = i_s_tvalid && o_s_tready;

    // Only a tick with a live frame yields a transfer; start requests while busy drop.
    assign emit  = advance && (r_in_func == lcdssw_pkg::FUNC_TICK) && r_active;
    assign start = advance && !r_active &&
                   ((r_in_func == lcdssw_pkg::FUNC_COMMAND) ||
                    (r_in_func == lcdssw_pkg::FUNC_REFRESH));

    // Edits go straight to the store, also in the middle of a frame.
    always_comb begin
        store_ctl            = '0;
        store_ctl.addr       = r_in_addr;
        store_ctl.bits       = r_in_bits;
        if (advance) begin
            case (r_in_func)
                lcdssw_pkg::FUNC_SET_BITS:  store_ctl.set_bits   = 1'b1;
                lcdssw_pkg::FUNC_CLR_BITS:  store_ctl.clear_bits = 1'b1;
                lcdssw_pkg::FUNC_FILL_ONES: store_ctl.fill_ones  = 1'b1;
                lcdssw_pkg::FUNC_CLEAR_ALL: store_ctl.clear_all  = 1'b1;
                default:                    store_ctl            = store_ctl;
            endcase
        end
    end

    // Nibble bits start right after the header, LSB of address 0 first.
    assign seg_pos = r_pos - POS_W'(lcdssw_pkg::HEADER_BITS);

    lcdssw_store #(
        .BUFFER_NIBBLES(BUFFER_NIBBLES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (store_ctl),
        .i_bit_idx(seg_pos[BIT_IDX_W-1:0]),
        .o_bit    (store_bit)
    );

    // Command bits MSB first at positions 3..10, then one trailing zero.
    assign cmd_idx = 4'(lcdssw_pkg::CMD_LAST_POS) - r_pos[3:0];
    assign cmd_bit = (r_pos <= POS_W'(lcdssw_pkg::CMD_LAST_POS)) ? r_cmd[cmd_idx[2:0]] : 1'b0;

    always_comb begin
        if (r_pos == POS_W'(0)) begin
            n_bit = 1'b1;
        end else if (r_pos == POS_W'(1)) begin
            n_bit = 1'b0;
        end else if (r_pos == POS_W'(2)) begin
            n_bit = r_kind;
        end else if (!r_kind) begin
            n_bit = cmd_bit;
        end else if (r_pos < POS_W'(lcdssw_pkg::HEADER_BITS)) begin
            n_bit = 1'b0;
        end else begin
            n_bit = store_bit;
        end
    end

    assign last_pos = r_kind ? POS_W'(WRITE_FRAME_BITS - 1)
                             : POS_W'(lcdssw_pkg::CMD_FRAME_BITS - 1);
    assign n_last   = (r_pos == last_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload of the input register; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_func <= lcdssw_pkg::t_func'(i_s_tuser);
            r_in_addr <= i_s_tdata[4:0];
            r_in_bits <= i_s_tdata[8:5];
            r_in_cmd  <= i_s_tdata[16:9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_kind   <= 1'b0;
            r_cmd    <= '0;
            r_pos    <= '0;
        end else if (start) begin
            r_active <= 1'b1;
            r_kind   <= (r_in_func == lcdssw_pkg::FUNC_REFRESH);
            r_cmd    <= r_in_cmd;
            r_pos    <= '0;
        end else if (emit) begin
            if (n_last) begin
                r_active <= 1'b0;
                r_pos    <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_bit  <= n_bit;
            r_out_last <= n_last;
            r_out_kind <= r_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, 1'b1, r_out_bit};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_kind;

    `LCDSSW_ASSERT(a_idle_pos, i_clk, i_rst_n, !r_active, r_pos == '0, "bit counter moved with no frame")
    `LCDSSW_ASSERT(a_pos_range, i_clk, i_rst_n, r_active, r_pos <= last_pos, "bit counter past frame end")
    `LCDSSW_ASSERT_NEXT(a_frame_end, i_clk, i_rst_n, emit && n_last, !r_active && r_out_valid && r_out_last, "frame did not close on its last bit")
    `LCDSSW_ASSERT(a_no_lost_result, i_clk, i_rst_n, emit, out_free, "result loaded over a pending one")

endmodule

FILE: rtl/lcdssw_store.sv
// Segment nibble store: per-nibble edit cells plus a single bit read port.
// Depends on lcdssw_pkg and lcd_segment_serial_writer_macros.svh.
`include "lcd_segment_serial_writer_macros.svh"

module lcdssw_store #(
    parameter int BUFFER_NIBBLES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lcdssw_pkg::t_store_ctl         i_ctl,
    input  logic [$clog2(4*BUFFER_NIBBLES)-1:0] i_bit_idx,
    output logic                           o_bit
);

    localparam int STORE_W = 4 * BUFFER_NIBBLES;

    logic [STORE_W-1:0] r_store;
    logic [STORE_W-1:0] n_store;

    // Each nibble decides its own next value; an address past the end hits nothing.
    for (genvar g = 0; g < BUFFER_NIBBLES; g++) begin : g_nib
        logic       hit;
        logic [3:0] cur;
        assign hit = ({1'b0, i_ctl.addr} == 6'(g));
        assign cur = r_store[4*g +: 4];
        always_comb begin
            if (i_ctl.fill_ones) begin
                n_store[4*g +: 4] = 4'hf;
            end else if (i_ctl.clear_all) begin
                n_store[4*g +: 4] = 4'h0;
            end else if (i_ctl.set_bits && hit) begin
                n_store[4*g +: 4] = cur | i_ctl.bits;
            end else if (i_ctl.clear_bits && hit) begin
                n_store[4*g +: 4] = cur & ~i_ctl.bits;
            end else begin
                n_store[4*g +: 4] = cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else begin
            r_store <= n_store;
        end
    end

    assign o_bit = r_store[i_bit_idx];

    `LCDSSW_ASSERT_NEXT(a_fill_ones, i_clk, i_rst_n, i_ctl.fill_ones, r_store == '1, "fill left zero bits")
    `LCDSSW_ASSERT_NEXT(a_clear_all, i_clk, i_rst_n, i_ctl.clear_all && !i_ctl.fill_ones, r_store == '0, "clear left set bits")

endmodule
